@@ hdl/y2r_pkg.sv @@
// Shared types and fixed-point constants for the YUV 4:2:2 to RGB converter.
package y2r_pkg;

  localparam int FracBits = 14;

  localparam int ProdW = 25;
  localparam int SumW  = 10;

  localparam logic signed [ProdW-1:0] COEF_RV = 25'sd22987;
  localparam logic signed [ProdW-1:0] COEF_GU = -25'sd5636;
  localparam logic signed [ProdW-1:0] COEF_GV = 25'sd11698;
  localparam logic signed [ProdW-1:0] COEF_BU = 25'sd29049;

  localparam logic PACK_YUYV = 1'b0;
  localparam logic PACK_UYVY = 1'b1;

  localparam logic CHAN_RGB = 1'b0;
  localparam logic CHAN_BGR = 1'b1;

  localparam logic CFG_PACKING = 1'b0;
  localparam logic CFG_CHANNEL = 1'b1;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } group_t;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } pixel_t;

  typedef struct packed {
    logic packing_order;
    logic channel_order;
  } cfg_t;

endpackage

@@ hdl/y2r_core.sv @@
// Combinational color conversion of one packed group into two pixels.
module y2r_core (
  input  y2r_pkg::group_t group_i,
  input  y2r_pkg::cfg_t   cfg_i,
  output y2r_pkg::pixel_t pix0_o,
  output y2r_pkg::pixel_t pix1_o
);

  logic [7:0] y0, y1, u_raw, v_raw;
  logic signed [7:0] u_s, v_s;
  logic signed [y2r_pkg::ProdW-1:0] prod_r, prod_g, prod_b;
  logic signed [y2r_pkg::ProdW-1:0] shr_r, shr_g, shr_b;
  logic signed [y2r_pkg::SumW-1:0] ofs_r, ofs_g, ofs_b;
  logic signed [y2r_pkg::SumW-1:0] y0_s, y1_s;

  function automatic logic [7:0] clamp8(input logic signed [y2r_pkg::SumW-1:0] s);
    logic [7:0] res;
    if (s[y2r_pkg::SumW-1]) begin
      res = 8'd0;
    end else if (s[8]) begin
      res = 8'd255;
    end else begin
      res = s[7:0];
    end
    return res;
  endfunction

  always_comb begin
    if (cfg_i.packing_order == y2r_pkg::PACK_UYVY) begin
      u_raw = group_i.byte0;
      y0    = group_i.byte1;
      v_raw = group_i.byte2;
      y1    = group_i.byte3;
    end else begin
      y0    = group_i.byte0;
      u_raw = group_i.byte1;
      y1    = group_i.byte2;
      v_raw = group_i.byte3;
    end
  end

  // Subtracting 128 from an unsigned byte is an inversion of its top bit.
  assign u_s = $signed({~u_raw[7], u_raw[6:0]});
  assign v_s = $signed({~v_raw[7], v_raw[6:0]});

  assign prod_r = y2r_pkg::COEF_RV * y2r_pkg::ProdW'(v_s);
  assign prod_g = y2r_pkg::COEF_GU * y2r_pkg::ProdW'(u_s)
                - y2r_pkg::COEF_GV * y2r_pkg::ProdW'(v_s);
  assign prod_b = y2r_pkg::COEF_BU * y2r_pkg::ProdW'(u_s);

  // The arithmetic shift rounds toward minus infinity.
  assign shr_r = prod_r >>> y2r_pkg::FracBits;
  assign shr_g = prod_g >>> y2r_pkg::FracBits;
  assign shr_b = prod_b >>> y2r_pkg::FracBits;

  assign ofs_r = shr_r[y2r_pkg::SumW-1:0];
  assign ofs_g = shr_g[y2r_pkg::SumW-1:0];
  assign ofs_b = shr_b[y2r_pkg::SumW-1:0];

  assign y0_s = $signed({2'b00, y0});
  assign y1_s = $signed({2'b00, y1});

  always_comb begin
    logic [7:0] r0, g0, b0, r1, g1, b1;
    r0 = clamp8(y0_s + ofs_r);
    g0 = clamp8(y0_s + ofs_g);
    b0 = clamp8(y0_s + ofs_b);
    r1 = clamp8(y1_s + ofs_r);
    g1 = clamp8(y1_s + ofs_g);
    b1 = clamp8(y1_s + ofs_b);
    pix0_o.chan1 = g0;
    pix1_o.chan1 = g1;
    if (cfg_i.channel_order == y2r_pkg::CHAN_BGR) begin
      pix0_o.chan0 = b0;
      pix0_o.chan2 = r0;
      pix1_o.chan0 = b1;
      pix1_o.chan2 = r1;
    end else begin
      pix0_o.chan0 = r0;
      pix0_o.chan2 = b0;
      pix1_o.chan0 = r1;
      pix1_o.chan2 = b1;
    end
  end

endmodule

@@ hdl/yuv422_to_rgb_converter.sv @@
// Top level of the YUV 4:2:2 to RGB converter with input and result registers.
// An accepted beat is held in the input register and then in the result register before it shows on the output.
// Throughput: one packed group, two pixels, per clock cycle when the output is not stalled.
// The conversion arithmetic sits between the input register and the result register.
// Reset clears both valid flags and sets both configuration registers to zero.
module yuv422_to_rgb_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte0_i,
  input  logic [7:0] byte1_i,
  input  logic [7:0] byte2_i,
  input  logic [7:0] byte3_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] first_pixel_chan0_o,
  output logic [7:0] first_pixel_chan1_o,
  output logic [7:0] first_pixel_chan2_o,
  output logic [7:0] second_pixel_chan0_o,
  output logic [7:0] second_pixel_chan1_o,
  output logic [7:0] second_pixel_chan2_o
);

  y2r_pkg::cfg_t   cfg_q;
  y2r_pkg::group_t group_q;
  y2r_pkg::pixel_t pix0_d, pix1_d, pix0_q, pix1_q;
  logic            in_valid_q;
  logic            out_valid_q;
  logic            out_adv;
  logic            in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        y2r_pkg::CFG_PACKING: cfg_q.packing_order <= cfg_data_i;
        y2r_pkg::CFG_CHANNEL: cfg_q.channel_order <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign out_adv    = !out_valid_q || out_ready_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_ready_o = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_adv) begin
      group_q <= '{byte0: byte0_i, byte1: byte1_i, byte2: byte2_i, byte3: byte3_i};
    end
    if (in_valid_q && out_adv) begin
      pix0_q <= pix0_d;
      pix1_q <= pix1_d;
    end
  end

  y2r_core u_core (
    .group_i (group_q),
    .cfg_i   (cfg_q),
    .pix0_o  (pix0_d),
    .pix1_o  (pix1_d)
  );

  assign out_valid_o          = out_valid_q;
  assign first_pixel_chan0_o  = pix0_q.chan0;
  assign first_pixel_chan1_o  = pix0_q.chan1;
  assign first_pixel_chan2_o  = pix0_q.chan2;
  assign second_pixel_chan0_o = pix1_q.chan0;
  assign second_pixel_chan1_o = pix1_q.chan1;
  assign second_pixel_chan2_o = pix1_q.chan2;

`ifndef SYNTH
  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("Input stage is empty but does not accept a beat.");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> in_valid_q)
    else $error("Accepted beat did not reach the input register.");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |=> (in_valid_q && out_valid_q))
    else $error("Beat dropped while the output was stalled.");

  a_stage_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("Converted beat did not reach the result register.");
`endif

endmodule
